// ----- sv/delimited_section_extractor_defines.svh -----
// Assertion macros for the delimited section extractor.
`ifndef DELIMITED_SECTION_EXTRACTOR_DEFINES_SVH
`define DELIMITED_SECTION_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DSE_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/dse_pkg.sv -----
// Constants and register indexes for the delimited section extractor.
package dse_pkg;

	localparam int unsigned NUM_PAIRS_DEF     = 2;
	localparam int unsigned MAX_DELIM_LEN_DEF = 8;
	localparam int unsigned POSITION_BITS_DEF = 32;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned DELIM_W     = 64;
	localparam int unsigned LENGTHS_W   = 16;
	localparam int unsigned FLAGS_W     = 4;
	localparam int unsigned RESULT_W    = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_START_FIRST  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_END_FIRST    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_START_SECOND = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_END_SECOND   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DELIM_LENGTHS = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_INCL_FLAGS   = 3'd5;

endpackage

// ----- sv/delimited_section_extractor.sv -----
// Delimited section extractor: reports framed sections, one byte per unstalled cycle.
// Takes one content byte per cycle on the in channel unless stalled and, once a section
// framed by a start and end delimiter closes, gives one result (pair, start offset,
// length); a byte marked last that closes nothing gives a found=0 result. Sustained
// rate is one byte per clock while out_ready holds; a byte passes the input register,
// the matchers and the result register. A waiting result holds the input off once the
// byte behind it fills the input register. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata only while no content is in flight; the block does not check.
module delimited_section_extractor #(
	parameter int unsigned NUM_PAIRS     = dse_pkg::NUM_PAIRS_DEF,
	parameter int unsigned MAX_DELIM_LEN = dse_pkg::MAX_DELIM_LEN_DEF,
	parameter int unsigned POSITION_BITS = dse_pkg::POSITION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dse_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dse_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      ch,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic                            pair_index,
	output logic [dse_pkg::RESULT_W-1:0]    start_offset,
	output logic [dse_pkg::RESULT_W-1:0]    section_length
);
	import dse_pkg::*;
	`include "delimited_section_extractor_defines.svh"

	localparam int unsigned PW = $clog2(MAX_DELIM_LEN + 1);
	// signed span for end - start: covers -(2^P + 6) .. 2^P
	localparam int unsigned DW = RESULT_W + 3;

	// configuration
	logic [DELIM_W-1:0]   start_delim_q [2];
	logic [DELIM_W-1:0]   end_delim_q [2];
	logic [LENGTHS_W-1:0] delim_lengths_q;
	logic [FLAGS_W-1:0]   inclusive_flags_q;

	// input stage
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	// matcher state
	logic [POSITION_BITS-1:0] byte_position_q, byte_position_d;
	logic                     section_open_q, section_open_d;
	logic                     active_pair_q, active_pair_d;
	logic [PW-1:0]            start_progress_q [NUM_PAIRS];
	logic [PW-1:0]            start_progress_d [NUM_PAIRS];
	logic [PW-1:0]            end_progress_q [NUM_PAIRS];
	logic [PW-1:0]            end_progress_d [NUM_PAIRS];
	logic [POSITION_BITS-1:0] open_start_offset_q, open_start_offset_d;

	// result register
	logic                out_valid_q;
	logic                found_q;
	logic                pair_index_q;
	logic [RESULT_W-1:0] start_offset_q;
	logic [RESULT_W-1:0] section_length_q;

	logic                go;
	logic                opened;
	logic                hit_close;
	logic [RESULT_W-1:0] close_len;
	logic [PW-1:0]       slen [NUM_PAIRS];
	logic [PW-1:0]       elen [NUM_PAIRS];
	logic                sincl [NUM_PAIRS];
	logic                eincl [NUM_PAIRS];
	logic [7:0]          sbyte [NUM_PAIRS];
	logic [7:0]          ebyte [NUM_PAIRS];
	logic signed [DW-1:0] sec_end;
	logic signed [DW-1:0] sec_len;

	function automatic logic [PW-1:0] pat_len(input logic [3:0] nib);
		if (32'(nib) > MAX_DELIM_LEN) begin
			return PW'(MAX_DELIM_LEN);
		end
		return PW'(nib);
	endfunction

	assign go       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delim_q[0]  <= '0;
			start_delim_q[1]  <= '0;
			end_delim_q[0]    <= '0;
			end_delim_q[1]    <= '0;
			delim_lengths_q   <= '0;
			inclusive_flags_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_FIRST:   start_delim_q[0]  <= cfg_wdata[DELIM_W-1:0];
				REG_END_FIRST:     end_delim_q[0]    <= cfg_wdata[DELIM_W-1:0];
				REG_START_SECOND:  start_delim_q[1]  <= cfg_wdata[DELIM_W-1:0];
				REG_END_SECOND:    end_delim_q[1]    <= cfg_wdata[DELIM_W-1:0];
				REG_DELIM_LENGTHS: delim_lengths_q   <= cfg_wdata[LENGTHS_W-1:0];
				REG_INCL_FLAGS:    inclusive_flags_q <= cfg_wdata[FLAGS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_PAIRS; i++) begin
			slen[i]  = pat_len(delim_lengths_q[8*i +: 4]);
			elen[i]  = pat_len(delim_lengths_q[8*i+4 +: 4]);
			sincl[i] = inclusive_flags_q[2*i];
			eincl[i] = inclusive_flags_q[2*i+1];
			sbyte[i] = 8'(start_delim_q[i] >> {start_progress_q[i], 3'b000});
			ebyte[i] = 8'(end_delim_q[i] >> {end_progress_q[i], 3'b000});
		end
	end

	always_comb begin
		byte_position_d     = last_s1 ? '0 : byte_position_q + 1'b1;
		section_open_d      = section_open_q;
		active_pair_d       = active_pair_q;
		open_start_offset_d = open_start_offset_q;
		start_progress_d    = start_progress_q;
		end_progress_d      = end_progress_q;
		opened              = 1'b0;
		hit_close           = 1'b0;
		close_len           = '0;
		sec_end             = '0;
		sec_len             = '0;
		if (!section_open_q) begin
			// pairs in order; the first completion wins and later pairs sit out this byte
			for (int i = 0; i < NUM_PAIRS; i++) begin
				if (!opened && start_progress_q[i] < slen[i]) begin
					if (sbyte[i] == ch_s1) begin
						if (PW'(start_progress_q[i] + 1'b1) == slen[i]) begin
							opened              = 1'b1;
							start_progress_d[i] = '0;
							end_progress_d[i]   = '0;
							section_open_d      = 1'b1;
							active_pair_d       = 1'(i);
							open_start_offset_d = sincl[i]
								? byte_position_q - POSITION_BITS'(slen[i]) + 1'b1
								: byte_position_q + 1'b1;
						end else begin
							start_progress_d[i] = PW'(start_progress_q[i] + 1'b1);
						end
					end else begin
						start_progress_d[i] = '0;
					end
				end
			end
		end else begin
			for (int i = 0; i < NUM_PAIRS; i++) begin
				if (active_pair_q == 1'(i) && end_progress_q[i] < elen[i]) begin
					if (ebyte[i] == ch_s1) begin
						if (PW'(end_progress_q[i] + 1'b1) == elen[i]) begin
							hit_close         = 1'b1;
							end_progress_d[i] = '0;
							section_open_d    = 1'b0;
							active_pair_d     = 1'b0;
							sec_end = eincl[i]
								? DW'(byte_position_q) + 1'b1
								: DW'(byte_position_q) - DW'(elen[i]) + 1'b1;
							sec_len = sec_end - DW'(open_start_offset_q);
							if (sec_len[DW-1]) begin
								close_len = '0;
							end else if (|sec_len[DW-2:RESULT_W]) begin
								close_len = '1;
							end else begin
								close_len = sec_len[RESULT_W-1:0];
							end
						end else begin
							end_progress_d[i] = PW'(end_progress_q[i] + 1'b1);
						end
					end else begin
						end_progress_d[i] = '0;
					end
				end
			end
		end
		if (last_s1) begin
			section_open_d      = 1'b0;
			active_pair_d       = 1'b0;
			open_start_offset_d = '0;
			for (int i = 0; i < NUM_PAIRS; i++) begin
				start_progress_d[i] = '0;
				end_progress_d[i]   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q     <= '0;
			section_open_q      <= 1'b0;
			active_pair_q       <= 1'b0;
			open_start_offset_q <= '0;
			for (int i = 0; i < NUM_PAIRS; i++) begin
				start_progress_q[i] <= '0;
				end_progress_q[i]   <= '0;
			end
		end else if (go) begin
			byte_position_q     <= byte_position_d;
			section_open_q      <= section_open_d;
			active_pair_q       <= active_pair_d;
			open_start_offset_q <= open_start_offset_d;
			start_progress_q    <= start_progress_d;
			end_progress_q      <= end_progress_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= hit_close || last_s1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// a close on the last byte wins over the no-close result
	always_ff @(posedge clk) begin
		if (go) begin
			found_q          <= hit_close;
			pair_index_q     <= hit_close ? active_pair_q : 1'b0;
			start_offset_q   <= hit_close ? RESULT_W'(open_start_offset_q) : '0;
			section_length_q <= hit_close ? close_len : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign pair_index     = pair_index_q;
	assign start_offset   = start_offset_q;
	assign section_length = section_length_q;

	`DSE_ASSERT_NEXT(a_last_clears, go && last_s1, !section_open_q && byte_position_q == '0, "last byte did not clear content state")
	`DSE_ASSERT_NEXT(a_close_gives_result, go && section_open_q && hit_close, out_valid_q && found_q, "section close produced no found result")
	`DSE_ASSERT_IMPLY(a_nofound_zero, out_valid_q && !found_q, !pair_index_q && start_offset_q == '0 && section_length_q == '0, "no-close result carries nonzero fields")

endmodule
